// File: sv/msfd_pkg.sv
package msfd_pkg;

	// Server pool size and derived widths
	localparam int MAX_SERVERS = 128;
	localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam int CNT_W = $clog2(MAX_SERVERS + 1);

	// Field widths
	localparam int TIME_W  = 17;
	localparam int SVC_W   = 10;
	localparam int FREE_W  = 32;
	localparam int WAIT_W  = 24;
	localparam int TOTAL_W = 40;
	localparam int COUNT_W = 16;
	localparam int SRV_W   = 8;
	localparam int SIDX_W  = 7;
	localparam int CFG_W   = 17;
	localparam int CFG_IDX_W = 2;

	// Register reset values
	localparam logic [TIME_W-1:0] OPEN_RESET    = TIME_W'(28800);
	localparam logic [TIME_W-1:0] CLOSE_RESET   = TIME_W'(61200);
	localparam logic [SRV_W-1:0]  SERVERS_RESET = SRV_W'(128);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OPEN_TIME      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLOSE_TIME     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SERVERS_IN_USE = 2'd2;

	// Operation codes
	localparam logic OP_JOB     = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	// Service minutes to seconds: s*60 = s*64 - s*4
	localparam int SVC_SEC_W = 16;

	function automatic logic [SVC_SEC_W-1:0] min_to_sec(input logic [SVC_W-1:0] m);
		logic [SVC_SEC_W-1:0] w;
		w = SVC_SEC_W'(m);
		return (w << 6) - (w << 2);
	endfunction

endpackage

// File: sv/multi_server_fcfs_dispatch.sv
// Multi-server first-come-first-served dispatcher.
// Input channel (in_valid/in_ready): one item per job or restart. op selects
// job arrival or restart; arrival_seconds must be nondecreasing across jobs.
// Output channel (out_valid/out_ready): exactly one result item per input item,
// held in an output register until taken.
// Config port: cfg_we/cfg_index/cfg_data, single-cycle writes, write only while idle.
// Sequence: a job scans servers_in_use (n) free times through one memory read port,
// one server per cycle, then picks, writes back and updates totals. A restart or a
// late job skips the scan and goes straight to the finish state.
// The scan loop over the single-port free-time memory sets the job rate.
// in_ready is high only while the sequencer is idle; one item is in work at a time.
// Reset: registers return to open=28800, close=61200, servers=128; all servers free
// at 28800, totals zero. Free times use per-server valid bits, so reset and restart
// take effect at once with no clearing pass.
// Receiver stall: a finished result waits in the output register; the next item can
// be taken and worked, and its result waits until the previous one is delivered.
module multi_server_fcfs_dispatch (
	input  logic                           clk,
	input  logic                           arst_n,
	// config
	input  logic                           cfg_we,
	input  logic [msfd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [msfd_pkg::CFG_W-1:0]     cfg_data,
	// input channel
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           op,
	input  logic [msfd_pkg::TIME_W-1:0]    arrival_seconds,
	input  logic [msfd_pkg::SVC_W-1:0]     service_minutes,
	// output channel
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           accepted,
	output logic [msfd_pkg::SIDX_W-1:0]    server_index,
	output logic [msfd_pkg::WAIT_W-1:0]    wait_seconds,
	output logic [msfd_pkg::TOTAL_W-1:0]   total_wait_seconds,
	output logic [msfd_pkg::COUNT_W-1:0]   served_count
);

	localparam int NS = msfd_pkg::MAX_SERVERS;
	localparam int IW = msfd_pkg::IDX_W;
	localparam int CW = msfd_pkg::CNT_W;
	localparam int FW = msfd_pkg::FREE_W;
	localparam int TW = msfd_pkg::TIME_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_PICK  = 3'd2;
	localparam logic [2:0] ST_WRITE = 3'd3;
	localparam logic [2:0] ST_TOTAL = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	// config registers
	logic [TW-1:0]                  open_q, close_q;
	logic [msfd_pkg::SRV_W-1:0]     servers_q;

	// sequencer and job context
	logic [2:0]                     state_q;
	logic [TW-1:0]                  arr_q;
	logic [msfd_pkg::SVC_W-1:0]     svc_q;
	logic [CW-1:0]                  n_q;
	logic [CW-1:0]                  issue_q;

	// free-time store: memory plus valid bits; invalid entries read as base_q
	logic [FW-1:0]                  mem [NS];
	logic [NS-1:0]                  vld_q;
	logic [TW-1:0]                  base_q;
	logic                           mem_we;

	// scan pipeline
	logic                           pend_s1;
	logic [FW-1:0]                  rdata_s1;
	logic                           vbit_s1;
	logic [IW-1:0]                  idx_s1;
	logic [FW-1:0]                  free_s1;

	// scan results
	logic                           found_q;
	logic [IW-1:0]                  fidx_q, midx_q, pick_q;
	logic [FW-1:0]                  ffree_q, min_q, start_q;

	// job results and running totals
	logic [msfd_pkg::WAIT_W-1:0]    wait_q;
	logic                           res_acc_q;
	logic [msfd_pkg::TOTAL_W-1:0]   total_q;
	logic [msfd_pkg::COUNT_W-1:0]   count_q;

	// output register
	logic                           out_valid_q;
	logic                           acc_out_q;
	logic [msfd_pkg::SIDX_W-1:0]    idx_out_q;
	logic [msfd_pkg::WAIT_W-1:0]    wait_out_q;
	logic [msfd_pkg::TOTAL_W-1:0]   total_out_q;
	logic [msfd_pkg::COUNT_W-1:0]   count_out_q;

	logic                           in_fire;
	logic                           out_load;
	logic [CW-1:0]                  n_c;
	logic [FW-1:0]                  arr32, open32;
	logic [FW-1:0]                  sel_free, t_max, start_c;
	logic [IW-1:0]                  sel_idx;
	logic [FW:0]                    end_sum;
	logic [FW-1:0]                  end_c;
	logic [FW-1:0]                  wait_full;
	logic [msfd_pkg::TOTAL_W:0]     total_sum;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_load = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	assign mem_we   = (state_q == ST_WRITE);

	assign arr32  = FW'(arr_q);
	assign open32 = FW'(open_q);

	// active server count, clamped to 1..MAX_SERVERS
	always_comb begin
		if (servers_q == '0) begin
			n_c = CW'(1);
		end else if (32'(servers_q) > 32'(NS)) begin
			n_c = CW'(NS);
		end else begin
			n_c = CW'(servers_q);
		end
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q    <= msfd_pkg::OPEN_RESET;
			close_q   <= msfd_pkg::CLOSE_RESET;
			servers_q <= msfd_pkg::SERVERS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				msfd_pkg::REG_OPEN_TIME:      open_q    <= cfg_data[TW-1:0];
				msfd_pkg::REG_CLOSE_TIME:     close_q   <= cfg_data[TW-1:0];
				msfd_pkg::REG_SERVERS_IN_USE: servers_q <= cfg_data[msfd_pkg::SRV_W-1:0];
				default: ;
			endcase
		end
	end

	// free-time memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[pick_q] <= end_c;
		end
		rdata_s1 <= mem[issue_q[IW-1:0]];
		vbit_s1  <= vld_q[issue_q[IW-1:0]];
		idx_s1   <= issue_q[IW-1:0];
	end

	assign free_s1 = vbit_s1 ? rdata_s1 : FW'(base_q);

	// pick: first free server, else earliest free time
	assign sel_free = found_q ? ffree_q : min_q;
	assign sel_idx  = found_q ? fidx_q : midx_q;
	assign t_max    = (sel_free > arr32) ? sel_free : arr32;
	assign start_c  = (t_max > open32) ? t_max : open32;

	// new free time, saturating at 32 bits
	assign end_sum = {1'b0, start_q} + (FW + 1)'(msfd_pkg::min_to_sec(svc_q));
	assign end_c   = end_sum[FW] ? '1 : end_sum[FW-1:0];

	assign wait_full = start_q - arr32;
	assign total_sum = {1'b0, total_q} + (msfd_pkg::TOTAL_W + 1)'(wait_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			arr_q     <= '0;
			svc_q     <= '0;
			n_q       <= '0;
			issue_q   <= '0;
			pend_s1   <= 1'b0;
			found_q   <= 1'b0;
			fidx_q    <= '0;
			ffree_q   <= '0;
			midx_q    <= '0;
			min_q     <= '0;
			start_q   <= '0;
			vld_q     <= '0;
			base_q    <= msfd_pkg::OPEN_RESET;
			total_q   <= '0;
			count_q   <= '0;
			res_acc_q <= 1'b0;
			wait_q    <= '0;
			pick_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						arr_q   <= arrival_seconds;
						svc_q   <= service_minutes;
						n_q     <= n_c;
						issue_q <= '0;
						found_q <= 1'b0;
						res_acc_q <= 1'b0;
						wait_q  <= '0;
						pick_q  <= '0;
						if (op == msfd_pkg::OP_RESTART) begin
							vld_q   <= '0;
							base_q  <= open_q;
							total_q <= '0;
							count_q <= '0;
							state_q <= ST_FIN;
						end else if (arrival_seconds > close_q) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					// issue one read a cycle; its compare lands in the cycle after the read
					if (issue_q < n_q) begin
						issue_q <= issue_q + CW'(1);
						pend_s1 <= 1'b1;
					end else begin
						pend_s1 <= 1'b0;
						if (!pend_s1) begin
							state_q <= ST_PICK;
						end
					end
					if (pend_s1) begin
						if (!found_q && free_s1 <= arr32) begin
							found_q <= 1'b1;
							fidx_q  <= idx_s1;
							ffree_q <= free_s1;
						end
						if (idx_s1 == '0 || free_s1 < min_q) begin
							min_q  <= free_s1;
							midx_q <= idx_s1;
						end
					end
				end
				ST_PICK: begin
					pick_q  <= sel_idx;
					start_q <= start_c;
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					vld_q[pick_q] <= 1'b1;
					wait_q    <= (wait_full > FW'({msfd_pkg::WAIT_W{1'b1}}))
						? '1 : wait_full[msfd_pkg::WAIT_W-1:0];
					res_acc_q <= 1'b1;
					state_q   <= ST_TOTAL;
				end
				ST_TOTAL: begin
					total_q <= total_sum[msfd_pkg::TOTAL_W] ? '1
						: total_sum[msfd_pkg::TOTAL_W-1:0];
					if (count_q != '1) begin
						count_q <= count_q + msfd_pkg::COUNT_W'(1);
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			acc_out_q   <= res_acc_q;
			idx_out_q   <= msfd_pkg::SIDX_W'(pick_q);
			wait_out_q  <= wait_q;
			total_out_q <= total_q;
			count_out_q <= count_q;
		end
	end

	assign out_valid          = out_valid_q;
	assign accepted           = acc_out_q;
	assign server_index       = idx_out_q;
	assign wait_seconds       = wait_out_q;
	assign total_wait_seconds = total_out_q;
	assign served_count       = count_out_q;

`ifndef SYNTHESIS
	a_served_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> served_count != '0)
		else $error("served item with zero count");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !accepted |-> server_index == '0 && wait_seconds == '0)
		else $error("rejected item carries index or wait");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> issue_q <= n_q)
		else $error("scan ran past server count");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && op == msfd_pkg::OP_RESTART |=> vld_q == '0 && total_q == '0)
		else $error("restart did not clear state");
`endif

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps

// Dispatcher testbench.
// An in-line scoreboard model tracks free time per server, the wait sum and the
// served count. Each accepted input item queues the result the block should give.
// A receive process compares every delivered result item against the queue head.
module tb;

	localparam int CFG_IDX_W   = msfd_pkg::CFG_IDX_W;
	localparam int CFG_W       = msfd_pkg::CFG_W;
	localparam int TIME_W      = msfd_pkg::TIME_W;
	localparam int SVC_W       = msfd_pkg::SVC_W;
	localparam int SRV_W       = msfd_pkg::SRV_W;
	localparam int FREE_W      = msfd_pkg::FREE_W;
	localparam int SIDX_W      = msfd_pkg::SIDX_W;
	localparam int WAIT_W      = msfd_pkg::WAIT_W;
	localparam int TOTAL_W     = msfd_pkg::TOTAL_W;
	localparam int COUNT_W     = msfd_pkg::COUNT_W;
	localparam int MAX_SERVERS = msfd_pkg::MAX_SERVERS;

	localparam logic [TIME_W-1:0] OPEN_RESET    = msfd_pkg::OPEN_RESET;
	localparam logic [TIME_W-1:0] CLOSE_RESET   = msfd_pkg::CLOSE_RESET;
	localparam logic [SRV_W-1:0]  SERVERS_RESET = msfd_pkg::SERVERS_RESET;

	localparam int LIMIT_CYCLES = 4_000_000;  // hang guard, well above the slowest run
	localparam int MAX_REPORTS  = 40;         // keep a broken build from flooding the log
	localparam int LAST_SECOND  = 86399;
	localparam int SEC_PER_MIN  = 60;
	localparam int SAT_JOBS     = 300;        // enough jobs on one server to saturate the wait
	localparam int HOLD_CYCLES  = 600;

	// index 3 decodes to no register; a write there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	localparam logic [TIME_W-1:0] DAY_LAST = TIME_W'(LAST_SECOND);
	localparam logic [TIME_W-1:0] TIME_TOP = '1;

	localparam logic [63:0] WAIT_TOP  = 64'hFF_FFFF;
	localparam logic [63:0] FREE_TOP  = 64'hFFFF_FFFF;
	localparam logic [63:0] TOTAL_TOP = 64'hFF_FFFF_FFFF;

	typedef struct packed {
		logic                 acc;
		logic [SIDX_W-1:0]    sidx;
		logic [WAIT_W-1:0]    wait_s;
		logic [TOTAL_W-1:0]   total;
		logic [COUNT_W-1:0]   count;
	} dispatch_result_t;

	// DUT ports; every input has a known value from time zero
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]      cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  op = msfd_pkg::OP_JOB;
	logic [TIME_W-1:0]     arrival_seconds = '0;
	logic [SVC_W-1:0]      service_minutes = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  accepted;
	logic [SIDX_W-1:0]     server_index;
	logic [WAIT_W-1:0]     wait_seconds;
	logic [TOTAL_W-1:0]    total_wait_seconds;
	logic [COUNT_W-1:0]    served_count;

	// Scoreboard copy of the block's registers and state
	logic [TIME_W-1:0]     reg_open;
	logic [TIME_W-1:0]     reg_close;
	logic [SRV_W-1:0]      reg_servers;
	logic [FREE_W-1:0]     srv_free [MAX_SERVERS];
	logic [TOTAL_W-1:0]    wait_sum;
	logic [COUNT_W-1:0]    jobs_served;

	dispatch_result_t      pending_results [$];

	int unsigned tx_idle_pct = 0;   // chance per cycle that the sender sits idle
	int unsigned rx_stall_pct = 0;  // chance per cycle that the receiver stalls
	int          rx_hold_len = 0;   // length of the next long receiver hold-off
	int          rx_hold_req = 0;   // long hold-offs requested so far
	logic        rx_hold = 1'b0;

	int cycle_count = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_errors = 0;

	multi_server_fcfs_dispatch dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.op                 (op),
		.arrival_seconds    (arrival_seconds),
		.service_minutes    (service_minutes),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.accepted           (accepted),
		.server_index       (server_index),
		.wait_seconds       (wait_seconds),
		.total_wait_seconds (total_wait_seconds),
		.served_count       (served_count)
	);

	always #5 clk = ~clk;

	// Hang guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("tb: timeout after %0d cycles", cycle_count);
			$display("tb: done, errors");
			$finish;
		end
	end

	task automatic report(input string what);
		if (n_errors < MAX_REPORTS)
			$display("tb: mismatch at cycle %0d: %s", cycle_count, what);
		n_errors++;
	endtask

	// Scoreboard step for one item: updates the model state and returns the
	// result item the block must produce.
	function automatic dispatch_result_t dispatch_job(input logic op_i,
			input logic [TIME_W-1:0] arr, input logic [SVC_W-1:0] svc);
		dispatch_result_t r;
		int n;
		int pick;
		logic [63:0] start;
		logic [63:0] w;
		logic [63:0] fin;
		logic [63:0] sum;
		r = '0;
		if (op_i == msfd_pkg::OP_RESTART) begin
			foreach (srv_free[i])
				srv_free[i] = FREE_W'(reg_open);
			wait_sum = '0;
			jobs_served = '0;
			return r;
		end
		// late job: nothing moves, totals reported as they stand
		if (arr > reg_close) begin
			r.total = wait_sum;
			r.count = jobs_served;
			return r;
		end
		// zero scans one server, anything past the pool scans the whole pool
		n = (reg_servers == '0) ? 1 : int'(reg_servers);
		if (n > MAX_SERVERS)
			n = MAX_SERVERS;
		// first server already free at arrival
		pick = -1;
		for (int i = 0; i < n; i++)
			if (pick < 0 && srv_free[i] <= FREE_W'(arr))
				pick = i;
		// otherwise the earliest free time, lowest index on a tie
		if (pick < 0) begin
			pick = 0;
			for (int i = 1; i < n; i++)
				if (srv_free[i] < srv_free[pick])
					pick = i;
		end
		start = 64'(srv_free[pick]);
		if (start < 64'(arr))
			start = 64'(arr);
		if (start < 64'(reg_open))
			start = 64'(reg_open);
		w = start - 64'(arr);
		if (w > WAIT_TOP)
			w = WAIT_TOP;
		fin = start + 64'(svc) * 64'(SEC_PER_MIN);
		if (fin > FREE_TOP)
			fin = FREE_TOP;
		srv_free[pick] = fin[FREE_W-1:0];
		sum = 64'(wait_sum) + w;
		if (sum > TOTAL_TOP)
			sum = TOTAL_TOP;
		wait_sum = sum[TOTAL_W-1:0];
		if (jobs_served != '1)
			jobs_served = jobs_served + COUNT_W'(1);
		r.acc = 1'b1;
		r.sidx = SIDX_W'(pick);
		r.wait_s = w[WAIT_W-1:0];
		r.total = wait_sum;
		r.count = jobs_served;
		return r;
	endfunction

	// Send one item. Entered in the time step of an edge; returns in the step of
	// the edge that accepted it, so the next call can keep valid high.
	task automatic send_item(input logic op_i, input logic [TIME_W-1:0] arr,
			input logic [SVC_W-1:0] svc);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= op_i;
		arrival_seconds <= arr;
		service_minutes <= svc;
		do @(posedge clk); while (in_ready !== 1'b1);
		pending_results.push_back(dispatch_job(op_i, arr, svc));
		n_sent++;
	endtask

	// Sender goes quiet until every queued result has been delivered.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
		msfd_pkg::REG_OPEN_TIME:      reg_open = val[TIME_W-1:0];
		msfd_pkg::REG_CLOSE_TIME:     reg_close = val[TIME_W-1:0];
		msfd_pkg::REG_SERVERS_IN_USE: reg_servers = val[SRV_W-1:0];
		default: ;
		endcase
	endtask

	// Registers only change with the block idle
	task automatic set_config(input logic [CFG_W-1:0] open_v, input logic [CFG_W-1:0] close_v,
			input logic [CFG_W-1:0] srv_v);
		drain();
		write_reg(msfd_pkg::REG_OPEN_TIME, open_v);
		write_reg(msfd_pkg::REG_CLOSE_TIME, close_v);
		write_reg(msfd_pkg::REG_SERVERS_IN_USE, srv_v);
	endtask

	// Receive side: check each delivered item, then pick next cycle's ready.
	always @(posedge clk) begin
		dispatch_result_t want;
		dispatch_result_t got;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			got = {accepted, server_index, wait_seconds, total_wait_seconds, served_count};
			if (pending_results.size() == 0) begin
				report($sformatf("result item with nothing expected (acc=%0d srv=%0d)",
					accepted, server_index));
			end else begin
				want = pending_results.pop_front();
				if (got !== want)
					report($sformatf({"exp acc=%0d srv=%0d wait=%0d total=%0d count=%0d,",
						" got acc=%0d srv=%0d wait=%0d total=%0d count=%0d"},
						want.acc, want.sidx, want.wait_s, want.total, want.count,
						got.acc, got.sidx, got.wait_s, got.total, got.count));
				n_checked++;
			end
		end
		out_ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
	end

	// Long receiver hold-off, counted here in cycles
	initial begin
		int holds_done;
		holds_done = 0;
		forever begin
			@(posedge clk);
			if (rx_hold_req > holds_done) begin
				holds_done++;
				rx_hold <= 1'b1;
				repeat (rx_hold_len) @(posedge clk);
				rx_hold <= 1'b0;
			end
		end
	end

	// Reset values: jobs before open wait for it, close is inclusive, late jobs carry
	// only the totals, and restarts (with every field bit set) give empty results.
	task automatic test_defaults();
		send_item(msfd_pkg::OP_JOB, TIME_W'(0), SVC_W'(0));
		send_item(msfd_pkg::OP_JOB, TIME_W'(28800), '1);
		send_item(msfd_pkg::OP_JOB, TIME_W'(61200), SVC_W'(5));
		send_item(msfd_pkg::OP_JOB, TIME_W'(61201), SVC_W'(5));
		send_item(msfd_pkg::OP_JOB, DAY_LAST, SVC_W'(9));
		send_item(msfd_pkg::OP_RESTART, TIME_TOP, '1);
		send_item(msfd_pkg::OP_JOB, TIME_TOP, '1);
	endtask

	// Register extremes and the odd corners of server selection
	task automatic test_register_extremes();
		set_config(CFG_W'(0), CFG_W'(TIME_TOP), CFG_W'(2));
		write_reg(REG_SPARE, CFG_W'($urandom()));
		send_item(msfd_pkg::OP_RESTART, TIME_W'(0), SVC_W'(0));
		send_item(msfd_pkg::OP_JOB, TIME_W'(100), '1);         // server 0
		send_item(msfd_pkg::OP_JOB, TIME_W'(100), SVC_W'(1));  // server 1
		send_item(msfd_pkg::OP_JOB, TIME_W'(150), SVC_W'(2));  // both busy: earliest free wins
		send_item(msfd_pkg::OP_JOB, TIME_W'(50), SVC_W'(0));   // arrival goes backwards
		set_config(CFG_W'(0), CFG_W'(TIME_TOP), CFG_W'(0));    // zero count
		send_item(msfd_pkg::OP_JOB, TIME_W'(60000), SVC_W'(7));
		set_config(CFG_W'(0), CFG_W'(TIME_TOP), CFG_W'(255));  // above the pool
		send_item(msfd_pkg::OP_JOB, TIME_W'(60000), SVC_W'(3));
		set_config(CFG_W'(0), CFG_W'(TIME_TOP), 17'h1_0003);  // bits above the field
		send_item(msfd_pkg::OP_JOB, TIME_W'(60000), SVC_W'(0));
		// later open time: free times stay, starts move up to open
		set_config(CFG_W'(DAY_LAST), CFG_W'(TIME_TOP), CFG_W'(3));
		send_item(msfd_pkg::OP_JOB, TIME_W'(1000), SVC_W'(5));
		send_item(msfd_pkg::OP_RESTART, TIME_W'(0), SVC_W'(0));
		send_item(msfd_pkg::OP_JOB, TIME_W'(0), SVC_W'(0));
		set_config(CFG_W'(OPEN_RESET), CFG_W'(CLOSE_RESET), CFG_W'(SERVERS_RESET));
	endtask

	// Mostly ordered arrival walks with random service, plus noise items
	// (arrival anywhere in the field) and restarts; four idle mixes.
	task automatic test_random_traffic();
		int step;
		int walk;
		int roll;
		logic [CFG_W-1:0] open_v;
		logic [CFG_W-1:0] close_v;
		logic [CFG_W-1:0] srv_v;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
			0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
			1: begin tx_idle_pct = 45; rx_stall_pct = 0;  end
			2: begin tx_idle_pct = 0;  rx_stall_pct = 45; end
			default: begin tx_idle_pct = 10; rx_stall_pct = 10; end
			endcase
			for (int seg = 0; seg < 4; seg++) begin
				case ($urandom_range(7))
				0: open_v = '0;
				1: open_v = CFG_W'(DAY_LAST);
				2: open_v = CFG_W'(TIME_TOP);
				default: open_v = CFG_W'($urandom_range(0, 43200));
				endcase
				case ($urandom_range(7))
				0: close_v = '0;
				1: close_v = CFG_W'(TIME_TOP);
				default: close_v = CFG_W'($urandom_range(43200, LAST_SECOND));
				endcase
				// full scans are slow, so most settings use a handful of servers
				case ($urandom_range(9))
				0: srv_v = CFG_W'(MAX_SERVERS);
				1: srv_v = CFG_W'(1);
				2: srv_v = '0;
				3: srv_v = CFG_W'(255);
				default: srv_v = CFG_W'($urandom_range(2, 8));
				endcase
				set_config(open_v, close_v, srv_v);
				if ($urandom_range(1) == 0)
					send_item(msfd_pkg::OP_RESTART, TIME_W'($urandom()), SVC_W'($urandom()));
				step = $urandom_range(20, 900);
				walk = $urandom_range(0, 36000);
				for (int k = 0; k < 80; k++) begin
					roll = $urandom_range(99);
					if (roll < 3) begin
						send_item(msfd_pkg::OP_RESTART, TIME_W'($urandom()),
							SVC_W'($urandom()));
					end else if (roll < 9) begin
						send_item(msfd_pkg::OP_JOB, TIME_W'($urandom()), SVC_W'($urandom()));
					end else begin
						walk += $urandom_range(0, step);
						if (walk > LAST_SECOND) begin
							// new day: restart and begin a fresh walk
							walk = $urandom_range(0, 3600);
							send_item(msfd_pkg::OP_RESTART, TIME_W'(walk), '0);
						end else begin
							send_item(msfd_pkg::OP_JOB, TIME_W'(walk),
								($urandom_range(9) == 0) ? SVC_W'($urandom()) :
								SVC_W'($urandom_range(0, 60)));
						end
					end
				end
			end
		end
	endtask

	// Receiver blocks for a long stretch while items keep coming: the output
	// register fills, the next job finishes behind it and the input stalls.
	task automatic test_backpressure();
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		set_config(CFG_W'(OPEN_RESET), CFG_W'(CLOSE_RESET), CFG_W'(2));
		rx_hold_len = HOLD_CYCLES;
		rx_hold_req++;
		for (int k = 0; k < 16; k++)
			send_item(msfd_pkg::OP_JOB, TIME_W'(30000 + 100 * k),
				SVC_W'($urandom_range(0, 90)));
		drain();
	endtask

	// One server, longest service, all jobs at second zero: the free time grows
	// by a fixed step per job until the wait runs into its top.
	task automatic test_saturation();
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		set_config(CFG_W'(0), CFG_W'(TIME_TOP), CFG_W'(1));
		send_item(msfd_pkg::OP_RESTART, '0, '0);
		repeat (SAT_JOBS)
			send_item(msfd_pkg::OP_JOB, '0, '1);
		drain();
	endtask

	initial begin
		reg_open = OPEN_RESET;
		reg_close = CLOSE_RESET;
		reg_servers = SERVERS_RESET;
		foreach (srv_free[i])
			srv_free[i] = FREE_W'(OPEN_RESET);
		wait_sum = '0;
		jobs_served = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_defaults();
		test_register_extremes();
		test_random_traffic();
		test_backpressure();
		test_saturation();

		drain();
		repeat (200) @(posedge clk);

		$display("tb: %0d items sent, %0d results checked, %0d mismatches",
			n_sent, n_checked, n_errors);
		$display("tb: reset values, register extremes, four idle mixes, output hold, wait saturation");
		if (n_errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
